@@ rtl/core/pair_cluster_builder_defines.svh @@
// assertion macros for the cluster builder
`ifndef PAIR_CLUSTER_BUILDER_DEFINES_SVH
`define PAIR_CLUSTER_BUILDER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PCB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCB_ASSERT(lbl, prop, msg)
`define PCB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/pcb_pkg.sv @@
`default_nettype none

package pcb_pkg;

  localparam int PCB_CLUSTERS = 32;
  localparam int PCB_SLOTS    = 64;

  localparam logic [16:0] THR_RESET = 17'd6554;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PAIR  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_ADD_THR   = 1'b0;
  localparam logic REG_MERGE_THR = 1'b1;

  typedef enum logic [2:0] {
    ACT_IGNORED,
    ACT_ADD_SECOND,
    ACT_ADD_FIRST,
    ACT_MERGED,
    ACT_CREATED,
    ACT_OVERFLOW,
    ACT_READ,
    ACT_CLEARED
  } action_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_SIZE_RD,
    S_SIZE_WAIT,
    S_SCAN,
    S_DECIDE,
    S_ADD_WAIT,
    S_MRG_LO,
    S_MRG_HI,
    S_MRG_COPY,
    S_MRG_SZ1,
    S_MRG_SZ2,
    S_NEW0,
    S_NEW1,
    S_RD_WAIT,
    S_RD_MEM,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic [5:0]  slot_select;
    logic [4:0]  cluster_select;
    logic [16:0] similarity;
    logic [11:0] second_page;
    logic [15:0] second_block;
    logic [11:0] first_page;
    logic [15:0] lead_block;
    logic [1:0]  opcode;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [11:0] member_page_out;
    logic [15:0] member_block_out;
    logic        member_valid;
    logic [4:0]  live_clusters;
    logic [6:0]  member_count;
    logic [4:0]  cluster_index;
    action_t     action;
  } out_word_t;

  typedef struct packed {
    logic [11:0] page;
    logic [15:0] blk;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/pair_cluster_builder.sv @@
// channel   dir  width  contents
// s_*       in   88     pair or command word, handshake tvalid/tready
// m_*       out  56     result word, one per input word
// cfg_*     in   17     threshold writes, index 0 add, 1 merge
//
// a pair scans every allocated cluster and each of its stored members through
// the single member memory port, then may add, create or merge. rst is
// synchronous, clears control and counts and sets both thresholds to
// THR_RESET; the memories are not swept, the allocation count masks stale
// sizes. one result register: the next word is taken while a result waits,
// and an item finishes only once that register is free.
`default_nettype none
`include "pair_cluster_builder_defines.svh"

module pair_cluster_builder #(
  parameter int CLUSTERS = pcb_pkg::PCB_CLUSTERS,
  parameter int SLOTS    = pcb_pkg::PCB_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // opcode, lead_block, first_page, second_block, second_page, similarity,
  // cluster_select, slot_select, zero pad
  input  wire logic [87:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // action, cluster_index, member_count, live_clusters, member_valid,
  // member_block_out, member_page_out, zero pad
  output logic [55:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data
);
  import pcb_pkg::*;

  localparam int CW    = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int NW    = $clog2(SLOTS);
  localparam int DEPTH = CLUSTERS * SLOTS;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] maddr(input logic [CW-1:0] c, input logic [SW-1:0] s);
    maddr = AW'(AW'(c) * AW'(SLOTS)) + AW'(s);
  endfunction

  state_t state, state_next;

  logic [16:0] add_thr, merge_thr;
  logic [CW-1:0] used;
  logic [4:0] live;

  in_word_t in_q;
  out_word_t res, res_out, out_q;

  entry_t member_mem [DEPTH];
  entry_t mem_q, mem_wdata;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;

  logic [NW-1:0] size_mem [CLUSTERS];
  logic [NW-1:0] sz_q, sz_wdata;
  logic sz_we, sz_re;
  logic [CW-1:0] sz_waddr, sz_raddr;

  logic [CW-1:0] c_idx, ci, cj, pend_c, tgt_c, lo_c, hi_c;
  logic [SW-1:0] s_idx, k;
  logic [NW-1:0] n_cur, nl, nh;
  logic fi, fj, pend, cp_pend;
  logic [AW-1:0] cp_dst;

  logic sim_add, do_add, do_merge, do_create, create_ovf, add_ovf, mrg_ovf;
  logic scan_last, copy_last, rd_in, rd_hit, out_free;
  logic [CW-1:0] dec_c, dec_lo, dec_hi;
  logic [NW-1:0] rd_cnt;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = out_q;
  assign out_free = !m_tvalid || m_tready;

  assign sim_add    = in_q.similarity >= add_thr;
  assign do_add     = (fi != fj) && sim_add;
  assign do_merge   = fi && fj && (ci != cj) && (in_q.similarity >= merge_thr);
  assign do_create  = !fi && !fj && sim_add;
  assign create_ovf = 32'(used) >= CLUSTERS - 1;
  assign add_ovf    = 32'(sz_q) + 1 > SLOTS - 2;
  assign mrg_ovf    = 32'(nl) + 32'(sz_q) > SLOTS - 2;
  assign dec_c      = fi ? ci : cj;
  assign dec_lo     = (ci < cj) ? ci : cj;
  assign dec_hi     = (ci < cj) ? cj : ci;
  assign scan_last  = 32'(s_idx) + 1 == 32'(n_cur);
  assign copy_last  = 32'(k) + 1 == 32'(nh);
  assign rd_in      = 32'(in_q.cluster_select) < 32'(used);
  assign rd_cnt     = rd_in ? sz_q : '0;
  assign rd_hit     = 32'(in_q.slot_select) < 32'(rd_cnt);

  always_comb begin
    res_out               = res;
    res_out.live_clusters = live;
  end

  // member store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      member_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= member_mem[mem_raddr];
    end
  end

  // cluster sizes, valid only below the allocation count
  always_ff @(posedge clk) begin
    if (sz_we) begin
      size_mem[sz_waddr] <= sz_wdata;
    end
    if (sz_re) begin
      sz_q <= size_mem[sz_raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (s_tvalid) state_next = S_START;
      S_START: begin
        case (in_q.opcode)
          OP_PAIR: state_next = S_SIZE_RD;
          OP_READ: state_next = S_RD_WAIT;
          default: state_next = S_OUT;
        endcase
      end
      S_SIZE_RD:   state_next = (c_idx == used) ? S_DECIDE : S_SIZE_WAIT;
      S_SIZE_WAIT: state_next = (sz_q == '0) ? S_SIZE_RD : S_SCAN;
      S_SCAN:      if (scan_last) state_next = S_SIZE_RD;
      S_DECIDE: begin
        if (do_add) begin
          state_next = S_ADD_WAIT;
        end else if (do_merge) begin
          state_next = S_MRG_LO;
        end else if (do_create && !create_ovf) begin
          state_next = S_NEW0;
        end else begin
          state_next = S_OUT;
        end
      end
      S_ADD_WAIT:  state_next = S_OUT;
      S_MRG_LO:    state_next = S_MRG_HI;
      S_MRG_HI:    state_next = mrg_ovf ? S_OUT : S_MRG_COPY;
      S_MRG_COPY:  if (copy_last) state_next = S_MRG_SZ1;
      S_MRG_SZ1:   state_next = S_MRG_SZ2;
      S_MRG_SZ2:   state_next = S_OUT;
      S_NEW0:      state_next = S_NEW1;
      S_NEW1:      state_next = S_OUT;
      S_RD_WAIT:   state_next = rd_hit ? S_RD_MEM : S_OUT;
      S_RD_MEM:    state_next = S_OUT;
      S_OUT:       if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = '0;
    sz_we     = 1'b0;
    sz_re     = 1'b0;
    sz_waddr  = '0;
    sz_raddr  = '0;
    sz_wdata  = '0;
    case (state)
      S_START: begin
        if (in_q.opcode == OP_READ) begin
          sz_re    = 1'b1;
          sz_raddr = CW'(in_q.cluster_select);
        end
      end
      S_SIZE_RD: begin
        sz_re    = (c_idx != used);
        sz_raddr = c_idx;
      end
      S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = maddr(c_idx, s_idx);
      end
      S_DECIDE: begin
        sz_re    = do_add || do_merge;
        sz_raddr = do_add ? dec_c : dec_lo;
      end
      S_ADD_WAIT: begin
        if (!add_ovf) begin
          mem_we    = 1'b1;
          mem_waddr = maddr(tgt_c, SW'(sz_q));
          mem_wdata = fi ? entry_t'{page: in_q.second_page, blk: in_q.second_block}
                         : entry_t'{page: in_q.first_page, blk: in_q.lead_block};
          sz_we     = 1'b1;
          sz_waddr  = tgt_c;
          sz_wdata  = NW'(32'(sz_q) + 1);
        end
      end
      S_MRG_LO: begin
        sz_re    = 1'b1;
        sz_raddr = hi_c;
      end
      S_MRG_COPY: begin
        mem_re    = 1'b1;
        mem_raddr = maddr(hi_c, k);
      end
      S_MRG_SZ1: begin
        sz_we    = 1'b1;
        sz_waddr = lo_c;
        sz_wdata = NW'(32'(nl) + 32'(nh));
      end
      S_MRG_SZ2: begin
        sz_we    = 1'b1;
        sz_waddr = hi_c;
        sz_wdata = '0;
      end
      S_NEW0: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(used, '0);
        mem_wdata = entry_t'{page: in_q.first_page, blk: in_q.lead_block};
      end
      S_NEW1: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(used, SW'(1));
        mem_wdata = entry_t'{page: in_q.second_page, blk: in_q.second_block};
        sz_we     = 1'b1;
        sz_waddr  = used;
        sz_wdata  = NW'(2);
      end
      S_RD_WAIT: begin
        mem_re    = rd_hit;
        mem_raddr = maddr(CW'(in_q.cluster_select), SW'(in_q.slot_select));
      end
      default: begin
      end
    endcase
    // merge copy lands in the cycle after its read
    if (cp_pend) begin
      mem_we    = 1'b1;
      mem_waddr = cp_dst;
      mem_wdata = mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      add_thr   <= THR_RESET;
      merge_thr <= THR_RESET;
      used      <= '0;
      live      <= '0;
      m_tvalid  <= 1'b0;
      pend      <= 1'b0;
      cp_pend   <= 1'b0;
    end else begin
      state   <= state_next;
      pend    <= (state == S_SCAN);
      pend_c  <= c_idx;
      cp_pend <= (state == S_MRG_COPY);
      cp_dst  <= maddr(lo_c, SW'(32'(nl) + 32'(k)));

      if (cfg_we) begin
        case (cfg_index)
          REG_ADD_THR:   add_thr <= cfg_data;
          REG_MERGE_THR: merge_thr <= cfg_data;
          default: begin
          end
        endcase
      end

      // first hit per block, scan runs in ascending cluster order
      if (pend) begin
        if (!fi && mem_q.blk == in_q.lead_block) begin
          fi <= 1'b1;
          ci <= pend_c;
        end
        if (!fj && mem_q.blk == in_q.second_block) begin
          fj <= 1'b1;
          cj <= pend_c;
        end
      end

      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_q  <= in_word_t'(s_tdata);
            fi    <= 1'b0;
            fj    <= 1'b0;
            c_idx <= '0;
            res   <= '0;
          end
        end
        S_START: begin
          case (in_q.opcode)
            OP_CLEAR: begin
              used       <= '0;
              live       <= '0;
              res.action <= ACT_CLEARED;
            end
            OP_READ: begin
              res.action        <= ACT_READ;
              res.cluster_index <= in_q.cluster_select;
            end
            default: begin
            end
          endcase
        end
        S_SIZE_WAIT: begin
          n_cur <= sz_q;
          s_idx <= '0;
          if (sz_q == '0) begin
            c_idx <= c_idx + 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            c_idx <= c_idx + 1'b1;
          end else begin
            s_idx <= s_idx + 1'b1;
          end
        end
        S_DECIDE: begin
          tgt_c <= dec_c;
          lo_c  <= dec_lo;
          hi_c  <= dec_hi;
          if (do_create && create_ovf && !do_add && !do_merge) begin
            res.action <= ACT_OVERFLOW;
          end
        end
        S_ADD_WAIT: begin
          if (add_ovf) begin
            res.action <= ACT_OVERFLOW;
          end else begin
            res.action        <= fi ? ACT_ADD_SECOND : ACT_ADD_FIRST;
            res.cluster_index <= 5'(tgt_c);
            res.member_count  <= 7'(32'(sz_q) + 1);
          end
        end
        S_MRG_LO: nl <= sz_q;
        S_MRG_HI: begin
          nh <= sz_q;
          k  <= '0;
          if (mrg_ovf) begin
            res.action <= ACT_OVERFLOW;
          end
        end
        S_MRG_COPY: k <= k + 1'b1;
        S_MRG_SZ2: begin
          live              <= live - 1'b1;
          res.action        <= ACT_MERGED;
          res.cluster_index <= 5'(lo_c);
          res.member_count  <= 7'(32'(nl) + 32'(nh));
        end
        S_NEW1: begin
          used              <= used + 1'b1;
          live              <= live + 1'b1;
          res.action        <= ACT_CREATED;
          res.cluster_index <= 5'(used);
          res.member_count  <= 7'd2;
        end
        S_RD_WAIT: res.member_count <= 7'(rd_cnt);
        S_RD_MEM: begin
          res.member_valid     <= 1'b1;
          res.member_block_out <= mem_q.blk;
          res.member_page_out  <= mem_q.page;
        end
        S_OUT: begin
          if (out_free) begin
            out_q <= res_out;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `PCB_ASSERT(a_used_bound, 32'(used) <= CLUSTERS - 1, "cluster allocation past capacity")
  `PCB_ASSERT(a_live_le_used, 32'(live) <= 32'(used), "live clusters exceed allocated")
  `PCB_ASSERT(a_no_write_in_scan, (state == S_SCAN) |-> !mem_we, "member write during scan")
  `PCB_ASSERT(a_copy_not_self, cp_pend |-> (lo_c != hi_c), "merge copies a cluster onto itself")

endmodule

`default_nettype wire

@@ tb/sv/pair_cluster_checker.sv @@
`default_nettype none

module pair_cluster_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  // opcode, lead_block, first_page, second_block, second_page, similarity,
  // cluster_select, slot_select, zero pad
  input  wire logic [87:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  // action, cluster_index, member_count, live_clusters, member_valid,
  // member_block_out, member_page_out, zero pad
  input  wire logic [55:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data,
  output int               errors,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcb_pkg::*;

  localparam int NCL = PCB_CLUSTERS;
  localparam int NSL = PCB_SLOTS;

  logic [15:0] store_blk [NCL*NSL];
  logic [11:0] store_page [NCL*NSL];
  int          cluster_len [NCL];
  int          alloc_count;
  logic [4:0]  live_total;
  logic [16:0] add_level;
  logic [16:0] merge_level;

  out_word_t   result_q [$];
  out_word_t   seen;
  out_word_t   wanted;
  int          fail_count = 0;

  function automatic bit find_home(input logic [15:0] blk, output int where);
    where = 0;
    for (int c = 0; c < alloc_count && c < NCL; c++) begin
      for (int s = 0; s < cluster_len[c] && s < NSL; s++) begin
        if (store_blk[c*NSL + s] == blk) begin
          where = c;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic out_word_t apply_word(input in_word_t w);
    out_word_t r;
    int ci, cj, c, n, lo, hi, nl, nh;
    bit fi, fj;
    r = '0;
    r.action = ACT_IGNORED;
    case (w.opcode)
      OP_CLEAR: begin
        foreach (cluster_len[k]) cluster_len[k] = 0;
        alloc_count = 0;
        live_total = '0;
        r.action = ACT_CLEARED;
      end
      OP_READ: begin
        r.action = ACT_READ;
        r.cluster_index = w.cluster_select;
        r.member_count = 7'(cluster_len[w.cluster_select]);
        if (w.slot_select < cluster_len[w.cluster_select]) begin
          r.member_valid = 1'b1;
          r.member_block_out = store_blk[w.cluster_select*NSL + w.slot_select];
          r.member_page_out = store_page[w.cluster_select*NSL + w.slot_select];
        end
      end
      OP_PAIR: begin
        fi = find_home(w.lead_block, ci);
        fj = find_home(w.second_block, cj);
        if (fi != fj && w.similarity >= add_level) begin
          c = fi ? ci : cj;
          n = cluster_len[c];
          if (n + 1 > NSL - 2) begin
            r.action = ACT_OVERFLOW;
          end else begin
            store_blk[c*NSL + n] = fi ? w.second_block : w.lead_block;
            store_page[c*NSL + n] = fi ? w.second_page : w.first_page;
            cluster_len[c] = n + 1;
            r.action = fi ? ACT_ADD_SECOND : ACT_ADD_FIRST;
            r.cluster_index = 5'(c);
            r.member_count = 7'(n + 1);
          end
        end else if (fi && fj && ci != cj && w.similarity >= merge_level) begin
          lo = (ci < cj) ? ci : cj;
          hi = (ci < cj) ? cj : ci;
          nl = cluster_len[lo];
          nh = cluster_len[hi];
          if (nl + nh > NSL - 2) begin
            r.action = ACT_OVERFLOW;
          end else begin
            for (int k = 0; k < nh; k++) begin
              store_blk[lo*NSL + nl + k] = store_blk[hi*NSL + k];
              store_page[lo*NSL + nl + k] = store_page[hi*NSL + k];
            end
            cluster_len[lo] = nl + nh;
            cluster_len[hi] = 0;
            live_total = live_total - 5'd1;
            r.action = ACT_MERGED;
            r.cluster_index = 5'(lo);
            r.member_count = 7'(nl + nh);
          end
        end else if (!fi && !fj && w.similarity >= add_level) begin
          if (alloc_count >= NCL - 1) begin
            r.action = ACT_OVERFLOW;
          end else begin
            c = alloc_count;
            store_blk[c*NSL] = w.lead_block;
            store_page[c*NSL] = w.first_page;
            store_blk[c*NSL + 1] = w.second_block;
            store_page[c*NSL + 1] = w.second_page;
            cluster_len[c] = 2;
            alloc_count = c + 1;
            live_total = live_total + 5'd1;
            r.action = ACT_CREATED;
            r.cluster_index = 5'(c);
            r.member_count = 7'd2;
          end
        end
      end
      default: ;
    endcase
    r.live_clusters = live_total;
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (cluster_len[k]) cluster_len[k] = 0;
      alloc_count = 0;
      live_total = '0;
      add_level = THR_RESET;
      merge_level = THR_RESET;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ADD_THR) begin
          add_level = cfg_data;
        end else begin
          merge_level = cfg_data;
        end
      end
      if (m_tvalid && m_tready) begin
        seen = out_word_t'(m_tdata);
        if (result_q.size() == 0) begin
          fail_count++;
          $display("%0t: result word expected none actual %0h", $time, m_tdata);
        end else begin
          wanted = result_q.pop_front();
          check_field("action", wanted.action, seen.action);
          check_field("cluster_index", wanted.cluster_index, seen.cluster_index);
          check_field("member_count", wanted.member_count, seen.member_count);
          check_field("live_clusters", wanted.live_clusters, seen.live_clusters);
          check_field("member_valid", wanted.member_valid, seen.member_valid);
          check_field("member_block_out", wanted.member_block_out,
                      seen.member_block_out);
          check_field("member_page_out", wanted.member_page_out,
                      seen.member_page_out);
        end
      end
      if (s_tvalid && s_tready) begin
        result_q.push_back(apply_word(in_word_t'(s_tdata)));
      end
    end
    errors <= fail_count;
    outstanding <= result_q.size();
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_pair_cluster_builder.sv @@
`default_nettype none

module tb_pair_cluster_builder;
  timeunit 1ns;
  timeprecision 1ps;
  import pcb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 2100;
  localparam int POOL_SIZE = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  // opcode, lead_block, first_page, second_block, second_page, similarity,
  // cluster_select, slot_select, zero pad
  logic [87:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // action, cluster_index, member_count, live_clusters, member_valid,
  // member_block_out, member_page_out, zero pad
  logic [55:0] m_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [16:0] cfg_data;
  int          errors;
  int          outstanding;

  bit          quiet_tail = 1'b0;
  logic [16:0] add_level = THR_RESET;
  logic [16:0] merge_level = THR_RESET;
  logic [15:0] id_pool [POOL_SIZE];

  always #5 clk = ~clk;

  pair_cluster_builder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pair_cluster_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .outstanding(outstanding)
  );

  function automatic in_word_t pair_word(input logic [15:0] b1, input logic [11:0] p1,
                                         input logic [15:0] b2, input logic [11:0] p2,
                                         input logic [16:0] sim);
    in_word_t w;
    w = '0;
    w.opcode = OP_PAIR;
    w.lead_block = b1;
    w.first_page = p1;
    w.second_block = b2;
    w.second_page = p2;
    w.similarity = sim;
    w.cluster_select = 5'($urandom);
    w.slot_select = 6'($urandom);
    return w;
  endfunction

  function automatic in_word_t read_word(input logic [4:0] c, input logic [5:0] s);
    in_word_t w;
    w = '0;
    w.opcode = OP_READ;
    w.cluster_select = c;
    w.slot_select = s;
    w.lead_block = 16'($urandom);
    w.second_page = 12'($urandom);
    return w;
  endfunction

  function automatic in_word_t cmd_word(input logic [1:0] op);
    in_word_t w;
    w = pair_word(16'($urandom), 12'($urandom), 16'($urandom), 12'($urandom),
                  17'($urandom_range(0, 65536)));
    w.opcode = op;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    w = cmd_word(OP_PAIR);
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      w.opcode = OP_CLEAR;
    end else if (pick < 5) begin
      w.opcode = OP_UNUSED;
    end else if (pick < 25) begin
      w.opcode = OP_READ;
      if ($urandom_range(0, 3) != 0) begin
        w.cluster_select = 5'($urandom_range(0, 7));
        w.slot_select = 6'($urandom_range(0, 9));
      end
    end else begin
      if ($urandom_range(0, 4) != 0) w.lead_block = id_pool[$urandom_range(0, POOL_SIZE-1)];
      if ($urandom_range(0, 4) != 0) w.second_block = id_pool[$urandom_range(0, POOL_SIZE-1)];
      if ($urandom_range(0, 9) < 7) begin
        w.similarity = 17'($urandom_range((add_level > merge_level) ? add_level : merge_level,
                                          65536));
      end
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    do @(posedge clk); while (!s_tready);
  endtask

  // sender holds off until every result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [16:0] add_value, input logic [16:0] merge_value);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_ADD_THR;
    cfg_data <= add_value;
    @(posedge clk);
    cfg_index <= REG_MERGE_THR;
    cfg_data <= merge_value;
    @(posedge clk);
    cfg_we <= 1'b0;
    add_level = add_value;
    merge_level = merge_value;
  endtask

  task automatic random_phase(input int count);
    foreach (id_pool[k]) id_pool[k] = 16'($urandom);
    repeat (count) send_word(random_word());
  endtask

  // allocate every cluster, then one more, then merge two of them
  task automatic fill_clusters();
    logic [15:0] base;
    base = 16'($urandom);
    send_word(cmd_word(OP_CLEAR));
    for (int i = 0; i <= PCB_CLUSTERS - 1; i++) begin
      send_word(pair_word(base + 16'(2*i), 12'($urandom), base + 16'(2*i + 1),
                          12'($urandom), 17'd65536));
    end
    send_word(read_word(5'd30, 6'd1));
    send_word(read_word(5'd31, 6'd0));
    send_word(pair_word(base + 16'd6, 12'd0, base + 16'd60, 12'hfff, 17'd65536));
    send_word(read_word(5'd3, 6'd3));
    send_word(read_word(5'd30, 6'd0));
    send_word(pair_word(base - 16'd1, 12'd1, base - 16'd2, 12'd2, 17'd65536));
  endtask

  // grow one cluster to capacity, then try merging into it
  task automatic grow_cluster();
    logic [15:0] base;
    base = 16'($urandom);
    send_word(cmd_word(OP_CLEAR));
    send_word(pair_word(base, 12'($urandom), base + 16'd1, 12'($urandom), 17'd65536));
    for (int i = 0; i < PCB_SLOTS - 3; i++) begin
      if (i % 2 == 0) begin
        send_word(pair_word(base, 12'($urandom), base + 16'(i + 2), 12'($urandom),
                            17'd65536));
      end else begin
        send_word(pair_word(base + 16'(i + 2), 12'($urandom), base, 12'($urandom),
                            17'd65536));
      end
    end
    send_word(read_word(5'd0, 6'd61));
    send_word(read_word(5'd0, 6'd62));
    send_word(pair_word(base + 16'd100, 12'd7, base + 16'd101, 12'd8, 17'd65536));
    send_word(pair_word(base + 16'd3, 12'd9, base + 16'd100, 12'd10, 17'd65536));
    send_word(pair_word(base + 16'd102, 12'd11, base + 16'd103, 12'd12, 17'd65536));
    send_word(pair_word(base + 16'd103, 12'd13, base + 16'd101, 12'd14, 17'd65536));
    send_word(read_word(5'd1, 6'd3));
    send_word(read_word(5'd2, 6'd0));
  endtask

  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (quiet_tail) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("pair_cluster_builder test failed");
    $finish;
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ADD_THR;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_thresholds(THR_RESET, 17'd20000);
    send_word(read_word(5'd0, 6'd0));
    send_word(cmd_word(OP_UNUSED));
    send_word(pair_word(16'h0000, 12'h000, 16'hffff, 12'hfff, 17'd65536));
    send_word(pair_word(16'h1234, 12'h0ab, 16'h1234, 12'h5a5, THR_RESET));
    send_word(pair_word(16'h7777, 12'h001, 16'h8888, 12'h002, THR_RESET - 17'd1));
    send_word(pair_word(16'h0000, 12'h003, 16'h4242, 12'h004, 17'd30000));
    send_word(pair_word(16'h5151, 12'h005, 16'hffff, 12'h006, 17'd30000));
    send_word(pair_word(16'h4242, 12'h007, 16'h5151, 12'h008, 17'd65536));
    send_word(pair_word(16'h1234, 12'h009, 16'h1234, 12'h00a, 17'd65536));
    send_word(pair_word(16'h4242, 12'h00b, 16'h1234, 12'h00c, 17'd19999));
    send_word(pair_word(16'h1234, 12'h00d, 16'h4242, 12'h00e, 17'd20000));
    for (int s = 0; s <= 6; s++) send_word(read_word(5'd0, 6'(s)));
    send_word(read_word(5'd1, 6'd0));
    send_word(read_word(5'd31, 6'd63));
    send_word(pair_word(16'haaaa, 12'h555, 16'h5555, 12'haaa, 17'd0));
    send_word(cmd_word(OP_CLEAR));
    send_word(read_word(5'd0, 6'd0));

    random_phase(30);
    set_thresholds(17'd0, 17'd0);
    random_phase(30);
    fill_clusters();
    set_thresholds(17'd65536, 17'd65536);
    grow_cluster();
    random_phase(30);
    set_thresholds(17'd30000, 17'd50000);
    random_phase(30);
    set_thresholds(17'd50000, 17'd1000);
    quiet_tail = 1'b1;
    random_phase(37);

    s_tvalid <= 1'b0;
    for (int n = 0; n < 200000 && outstanding != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("pair_cluster_builder test passed");
    end else begin
      $display("pair_cluster_builder test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
